// ===== src/priority_slot_buffer_assert.svh =====
// assertion macros for the priority slot buffer checker
`ifndef PRIORITY_SLOT_BUFFER_ASSERT_SVH
`define PRIORITY_SLOT_BUFFER_ASSERT_SVH

// checked only out of reset
`define PSB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// checked on every edge, reset included
`define PSB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== src/psb_pkg.sv =====
package psb_pkg;

    localparam int PSB_SLOTS   = 16;
    localparam int PSB_SOURCES = 3;

    localparam logic [9:0] PRIO_BOUND = 10'd999;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_REMOVED  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] item_value;
        logic        [7:0]  item_priority;
        logic        [1:0]  item_source;
    } item_t;

    typedef struct packed {
        logic        [1:0]  status;
        logic        [3:0]  slot_used;
        logic signed [31:0] out_value;
        logic        [7:0]  out_priority;
        logic        [1:0]  out_source;
        logic        [4:0]  occupancy;
        logic signed [31:0] total_sum;
        logic signed [31:0] source_sum;
    } result_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic        [7:0]  prio;
        logic        [1:0]  source;
    } entry_t;

    typedef struct packed {
        logic   busy;
        logic   done;
        logic   found;
        entry_t entry;
    } scan_stat_t;

endpackage

// ===== src/psb_ram.sv =====
module psb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/psb_scan.sv =====
module psb_scan import psb_pkg::*; #(
    parameter int SLOTS = PSB_SLOTS,
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int CW = $clog2(SLOTS + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic             op,
    input  logic [SLOTS-1:0] active,
    input  entry_t           rd_entry,
    output logic [IW-1:0]    rd_addr,
    output logic [IW-1:0]    slot,
    output scan_stat_t       stat
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          pvalid_reg, pvalid_next;
    logic          found_reg, found_next;
    logic [IW-1:0] pidx_reg, pidx_next;
    logic [9:0]    best_prio_reg, best_prio_next;
    logic [IW-1:0] best_slot_reg, best_slot_next;
    entry_t        best_entry_reg, best_entry_next;
    logic          take;

    // shared compare: free slot on insert, smaller priority on remove
    always_comb
    begin
        if (op == OP_INSERT)
        begin
            take = pvalid_reg && !active[pidx_reg] && !found_reg;
        end
        else
        begin
            take = pvalid_reg && active[pidx_reg] && ({2'b00, rd_entry.prio} < best_prio_reg);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pvalid_next     = pvalid_reg;
        found_next      = found_reg;
        pidx_next       = pidx_reg;
        best_prio_next  = best_prio_reg;
        best_slot_next  = best_slot_reg;
        best_entry_next = best_entry_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    state_next     = S_SCAN;
                    cnt_next       = '0;
                    pvalid_next    = 1'b0;
                    found_next     = 1'b0;
                    best_prio_next = PRIO_BOUND;
                end
            end
            S_SCAN:
            begin
                if (take)
                begin
                    found_next      = 1'b1;
                    best_prio_next  = {2'b00, rd_entry.prio};
                    best_slot_next  = pidx_reg;
                    best_entry_next = rd_entry;
                end
                if (cnt_reg < CW'(SLOTS))
                begin
                    pvalid_next = 1'b1;
                    pidx_next   = cnt_reg[IW-1:0];
                    cnt_next    = cnt_reg + CW'(1);
                end
                else
                begin
                    pvalid_next = 1'b0;
                    state_next  = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            pvalid_reg <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            pvalid_reg <= pvalid_next;
            found_reg  <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg       <= pidx_next;
        best_prio_reg  <= best_prio_next;
        best_slot_reg  <= best_slot_next;
        best_entry_reg <= best_entry_next;
    end

    assign rd_addr     = cnt_reg[IW-1:0];
    assign slot        = best_slot_reg;
    assign stat.busy   = (state_reg != S_IDLE);
    assign stat.done   = (state_reg == S_FIN);
    assign stat.found  = found_reg;
    assign stat.entry  = best_entry_reg;

endmodule

// ===== src/priority_slot_buffer.sv =====
// priority slot buffer
// command port: item is taken on a rising edge with start high and busy low.
// item.operation selects insert (value, priority, source go to the lowest
// free slot) or remove (smallest priority number, lowest slot on a tie).
// result port: done is high for exactly one cycle with the result struct;
// the receiver cannot stall, so each result must be taken in that cycle.
// timing: a command scans the slots one per cycle through a single compare
// unit fed by the entry ram, and then the result is registered; done shows
// in the cycle after that, with busy already low, so a new command may be
// taken on the edge that ends done. commands never overlap in the scan.
// full on insert or empty on remove is reported in status and changes nothing.
// running totals wrap at 32 bits; a source index at or above SOURCES adds to
// the total only and reports a zero source sum.
// reset clears the active marks, occupancy and all sums; entry contents are
// not cleared and need no clearing pass, only entries of active slots are used.
module priority_slot_buffer import psb_pkg::*; #(
    parameter int SLOTS   = PSB_SLOTS,
    parameter int SOURCES = PSB_SOURCES
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  item_t   item,
    output logic    busy,
    output logic    done,
    output result_t result
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int SW = (SOURCES > 1) ? $clog2(SOURCES) : 1;

    item_t         item_reg;
    logic [SLOTS-1:0] active_reg;
    logic [CW-1:0] count_reg;
    logic [31:0]   total_reg;
    logic [31:0]   src_sum_reg [SOURCES];
    result_t       res_reg, res_next;
    logic          done_reg;

    scan_stat_t    stat;
    logic [IW-1:0] slot;
    logic [IW-1:0] rd_addr;
    entry_t        rd_entry;
    entry_t        wr_entry;
    logic          wr_en;
    logic          accept;
    logic          is_ins;
    logic [1:0]    src;
    logic          src_ok;
    logic [SW-1:0] src_idx;
    logic [31:0]   total_add;
    logic [31:0]   src_add;

    assign accept = start && !stat.busy;

    psb_scan #(
        .SLOTS(SLOTS)
    ) u_psb_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (accept),
        .op       (item_reg.operation),
        .active   (active_reg),
        .rd_entry (rd_entry),
        .rd_addr  (rd_addr),
        .slot     (slot),
        .stat     (stat)
    );

    psb_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(SLOTS)
    ) u_psb_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (slot),
        .wdata (wr_entry),
        .raddr (rd_addr),
        .rdata (rd_entry)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
    end

    assign is_ins          = (item_reg.operation == OP_INSERT);
    assign wr_en           = stat.done && is_ins && stat.found;
    assign wr_entry.value  = item_reg.item_value;
    assign wr_entry.prio   = item_reg.item_priority;
    assign wr_entry.source = item_reg.item_source;

    assign src       = stat.entry.source;
    assign src_ok    = ({2'b00, src} < 4'(SOURCES));
    assign src_idx   = SW'(src);
    assign total_add = total_reg + $unsigned(stat.entry.value);
    assign src_add   = src_sum_reg[src_idx] + $unsigned(stat.entry.value);

    always_comb
    begin
        res_next           = '0;
        res_next.occupancy = 5'(count_reg);
        res_next.total_sum = total_reg;
        if (is_ins)
        begin
            if (stat.found)
            begin
                res_next.status    = ST_INSERTED;
                res_next.slot_used = 4'(slot);
                res_next.occupancy = 5'(count_reg + CW'(1));
            end
            else
            begin
                res_next.status = ST_FULL;
            end
        end
        else
        begin
            if (stat.found)
            begin
                res_next.status       = ST_REMOVED;
                res_next.slot_used    = 4'(slot);
                res_next.out_value    = stat.entry.value;
                res_next.out_priority = stat.entry.prio;
                res_next.out_source   = stat.entry.source;
                res_next.occupancy    = 5'(count_reg - CW'(1));
                res_next.total_sum    = total_add;
                res_next.source_sum   = src_ok ? src_add : 32'd0;
            end
            else
            begin
                res_next.status = ST_EMPTY;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            count_reg  <= '0;
            total_reg  <= '0;
            done_reg   <= 1'b0;
            for (int i = 0; i < SOURCES; i++)
            begin
                src_sum_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= stat.done;
            if (stat.done && stat.found)
            begin
                if (is_ins)
                begin
                    active_reg[slot] <= 1'b1;
                    count_reg        <= count_reg + CW'(1);
                end
                else
                begin
                    active_reg[slot] <= 1'b0;
                    count_reg        <= count_reg - CW'(1);
                    total_reg        <= total_add;
                    if (src_ok)
                    begin
                        src_sum_reg[src_idx] <= src_add;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.done)
        begin
            res_reg <= res_next;
        end
    end

    assign busy   = stat.busy;
    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== src/psb_checker.sv =====
`include "priority_slot_buffer_assert.svh"

module psb_checker import psb_pkg::*; #(
    parameter int SLOTS = PSB_SLOTS
) (
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result
);

    `PSB_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> (!done && !busy), "activity during reset")
    `PSB_ASSERT(a_accept_busy, (start && !busy) |=> busy, "command transfer did not raise busy")
    `PSB_ASSERT(a_done_idle, done |-> !busy, "result shown while still busy")
    `PSB_ASSERT(a_done_pulse, done |=> !done, "result strobe longer than one cycle")
    `PSB_ASSERT(a_full_occ, (done && result.status == ST_FULL) |-> (result.occupancy == 5'(SLOTS) && result.slot_used == 4'd0), "full report with wrong occupancy")

endmodule

bind priority_slot_buffer psb_checker #(
    .SLOTS(SLOTS)
) u_psb_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
